/* rtl/saq_pkg.sv */
// Shared types for the sorted alarm queue: result kinds and cell commands.
package saq_pkg;

  // Result kind codes
  typedef enum logic [1:0] {
    KindAccepted = 2'd0,
    KindFull     = 2'd1,
    KindDue      = 2'd2,
    KindNone     = 2'd3
  } kind_e;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;  // insert the broadcast key in sorted position
    logic pop;  // drop the head, every cell takes its right neighbor
  } cell_cmd_t;

endpackage

/* rtl/saq_cell.sv */
// One storage cell of the sorted chain: holds a time and a tag, shifts either way.
module saq_cell #(
  parameter int TIME_BITS = 32,
  parameter int TAG_BITS  = 16
) (
  input  logic                  clk_i,
  input  saq_pkg::cell_cmd_t    cmd_i,
  input  logic [TIME_BITS-1:0]  key_time_i,
  input  logic [TAG_BITS-1:0]   key_tag_i,
  input  logic                  occ_i,
  input  logic                  left_occ_i,
  input  logic                  left_gt_i,
  input  logic [TIME_BITS-1:0]  left_time_i,
  input  logic [TAG_BITS-1:0]   left_tag_i,
  input  logic [TIME_BITS-1:0]  right_time_i,
  input  logic [TAG_BITS-1:0]   right_tag_i,
  output logic [TIME_BITS-1:0]  time_o,
  output logic [TAG_BITS-1:0]   tag_o,
  output logic                  gt_o
);

  logic [TIME_BITS-1:0] time_q, time_d;
  logic [TAG_BITS-1:0]  tag_q, tag_d;
  logic                 shift_in, take_key;

  // Own time is strictly later than the broadcast key
  assign gt_o = time_q > key_time_i;

  // Insert: left neighbor moves right if it is later than the key; the new
  // entry lands in the first cell that is empty or later, behind all ties.
  assign shift_in = left_occ_i && left_gt_i;
  assign take_key = (!occ_i || gt_o) && !shift_in;

  always_comb begin
    time_d = time_q;
    tag_d  = tag_q;
    if (cmd_i.ins) begin
      if (shift_in) begin
        time_d = left_time_i;
        tag_d  = left_tag_i;
      end else if (take_key) begin
        time_d = key_time_i;
        tag_d  = key_tag_i;
      end
    end else if (cmd_i.pop) begin
      time_d = right_time_i;
      tag_d  = right_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    tag_q  <= tag_d;
  end

  assign time_o = time_q;
  assign tag_o  = tag_q;

endmodule

/* rtl/sorted_alarm_queue.sv */
// Top level of the sorted alarm queue: control sequencer over a chain of cells.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------
//   in      | input     | in_valid_i / in_ready_o | op_i, event_time_i, alarm_tag_i
//   out     | output    | out_valid_o/out_ready_i | kind_o, due_tag_o, last_o
//
// An add registers the transaction, then every cell compares against the key
// and the chain shifts right in one step.
// A tick gives one result per due alarm, or one none result if none is due (at least
// one result); one head pop per cycle unless the output stalls, limited by the single head comparison per cycle.
// Reset clears only the state, the entry count and the output valid; cell contents need no clearing pass.
// A stalled output holds the sequencer; a new input is taken once the
// final result of the previous transaction sits in the output register.
module sorted_alarm_queue #(
  parameter int DEPTH     = 64,
  parameter int TIME_BITS = 32,
  parameter int TAG_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [TIME_BITS-1:0]  event_time_i,
  input  logic [TAG_BITS-1:0]   alarm_tag_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            kind_o,
  output logic [TAG_BITS-1:0]   due_tag_o,
  output logic                  last_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    StIdle,
    StAdd,
    StTick
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [TIME_BITS-1:0] key_time_q, key_time_d;
  logic [TAG_BITS-1:0]  key_tag_q, key_tag_d;
  logic                 out_valid_q, out_valid_d;
  saq_pkg::kind_e       kind_q, kind_d;
  logic [TAG_BITS-1:0]  due_tag_q, due_tag_d;
  logic                 last_q, last_d;

  saq_pkg::cell_cmd_t   cmd;
  logic                 emit_ok;

  logic [TIME_BITS-1:0] time_w [DEPTH];
  logic [TAG_BITS-1:0]  tag_w  [DEPTH];
  logic [DEPTH-1:0]     gt_w;
  logic [DEPTH-1:0]     occ_w;

  // Chain of cells, occupancy decoded from the entry count
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic                 left_occ, left_gt;
    logic [TIME_BITS-1:0] left_time, right_time;
    logic [TAG_BITS-1:0]  left_tag, right_tag;

    assign occ_w[i] = IDX < count_q;

    if (i == 0) begin : g_head
      assign left_occ  = 1'b0;
      assign left_gt   = 1'b0;
      assign left_time = key_time_q;
      assign left_tag  = key_tag_q;
    end else begin : g_body
      assign left_occ  = occ_w[i-1];
      assign left_gt   = gt_w[i-1];
      assign left_time = time_w[i-1];
      assign left_tag  = tag_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_time = time_w[i];
      assign right_tag  = tag_w[i];
    end else begin : g_inner
      assign right_time = time_w[i+1];
      assign right_tag  = tag_w[i+1];
    end

    saq_cell #(
      .TIME_BITS (TIME_BITS),
      .TAG_BITS  (TAG_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .key_time_i   (key_time_q),
      .key_tag_i    (key_tag_q),
      .occ_i        (occ_w[i]),
      .left_occ_i   (left_occ),
      .left_gt_i    (left_gt),
      .left_time_i  (left_time),
      .left_tag_i   (left_tag),
      .right_time_i (right_time),
      .right_tag_i  (right_tag),
      .time_o       (time_w[i]),
      .tag_o        (tag_w[i]),
      .gt_o         (gt_w[i])
    );
  end

  // Output slot can be loaded when empty or being drained this cycle
  assign emit_ok = !out_valid_q || out_ready_i;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    key_time_d  = key_time_q;
    key_tag_d   = key_tag_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    due_tag_d   = due_tag_q;
    last_d      = last_q;
    cmd         = '0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          key_time_d = event_time_i;
          key_tag_d  = alarm_tag_i;
          state_d    = op_i ? StTick : StAdd;
        end
      end
      StAdd: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          due_tag_d   = '0;
          last_d      = 1'b1;
          if (count_q == FULL_CNT) begin
            kind_d = saq_pkg::KindFull;
          end else begin
            kind_d  = saq_pkg::KindAccepted;
            cmd.ins = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
          state_d = StIdle;
        end
      end
      StTick: begin
        if (emit_ok) begin
          out_valid_d = 1'b1;
          if (occ_w[0] && !gt_w[0]) begin
            // Head is due: report it and pop; last when the next one is not due
            kind_d    = saq_pkg::KindDue;
            due_tag_d = tag_w[0];
            last_d    = !(occ_w[1] && !gt_w[1]);
            cmd.pop   = 1'b1;
            count_d   = count_q - CNT_W'(1);
            if (!(occ_w[1] && !gt_w[1])) begin
              state_d = StIdle;
            end
          end else begin
            kind_d    = saq_pkg::KindNone;
            due_tag_d = '0;
            last_d    = 1'b1;
            state_d   = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_time_q <= key_time_d;
    key_tag_q  <= key_tag_d;
    kind_q     <= kind_d;
    due_tag_q  <= due_tag_d;
    last_q     <= last_d;
  end

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign due_tag_o   = due_tag_q;
  assign last_o      = last_q;

  // Checks
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("entry count above depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (count_q == $past(count_q) ||
                       count_q == $past(count_q) + CNT_W'(1) ||
                       count_q + CNT_W'(1) == $past(count_q)))
    else $error("entry count moved by more than one");

  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != saq_pkg::KindDue |-> last_o && due_tag_o == '0)
    else $error("non-due result must be final and carry a zero tag");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a transaction is in progress");

endmodule

/* tb/tb.sv */
// Testbench for the sorted alarm queue: randomized stimulus, shadow queue, result checks.
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH     = 64;
  localparam int TIME_BITS = 32;
  localparam int TAG_BITS  = 16;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Receiver stall patterns
  localparam int READY_ALWAYS = 0;
  localparam int READY_HALF   = 1;
  localparam int READY_SPARSE = 2;

  localparam int  ITEM_TARGET   = 155;
  localparam int  HOLD_CYCLES   = 400;
  localparam int  HOLD_TRIGGER  = 30;
  localparam int  DRAIN_CYCLES  = 100;
  localparam time TIMEOUT_NS    = 3_000_000;

  typedef struct packed {
    logic                 op;
    logic [TIME_BITS-1:0] event_time;
    logic [TAG_BITS-1:0]  alarm_tag;
  } alarm_item_t;

  typedef struct packed {
    saq_pkg::kind_e      kind;
    logic [TAG_BITS-1:0] tag;
    logic                last;
  } outcome_t;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 op         = OP_ADD;
  logic [TIME_BITS-1:0] event_time = '0;
  logic [TAG_BITS-1:0]  alarm_tag  = '0;
  logic                 out_ready  = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic [1:0]           kind;
  logic [TAG_BITS-1:0]  due_tag;
  logic                 last;

  alarm_item_t stim_items[$];
  outcome_t    pending_outcomes[$];

  // Shadow copy of the sorted queue
  logic [TIME_BITS-1:0] shadow_times[DEPTH];
  logic [TAG_BITS-1:0]  shadow_tags[DEPTH];
  int                   shadow_count = 0;

  int mismatch_count = 0;
  int results_seen   = 0;

  sorted_alarm_queue #(
    .DEPTH    (DEPTH),
    .TIME_BITS(TIME_BITS),
    .TAG_BITS (TAG_BITS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (op),
    .event_time_i(event_time),
    .alarm_tag_i (alarm_tag),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .kind_o      (kind),
    .due_tag_o   (due_tag),
    .last_o      (last)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Insert or pop on the shadow queue and record the results the block must produce
  function automatic void alarm_queue_step(alarm_item_t item);
    int       pos;
    int       popped;
    outcome_t res;
    if (item.op == OP_ADD) begin
      if (shadow_count >= DEPTH) begin
        res = '{saq_pkg::KindFull, '0, 1'b1};
        pending_outcomes.push_back(res);
        return;
      end
      pos = shadow_count;
      // later entries move right; equal times stay ahead of the new one
      while (pos > 0 && shadow_times[pos-1] > item.event_time) begin
        shadow_times[pos] = shadow_times[pos-1];
        shadow_tags[pos]  = shadow_tags[pos-1];
        pos--;
      end
      shadow_times[pos] = item.event_time;
      shadow_tags[pos]  = item.alarm_tag;
      shadow_count++;
      res = '{saq_pkg::KindAccepted, '0, 1'b0};
      res.last = 1'b1;
      pending_outcomes.push_back(res);
    end else begin
      popped = 0;
      while (shadow_count > 0 && shadow_times[0] <= item.event_time) begin
        res = '{saq_pkg::KindDue, shadow_tags[0], 1'b0};
        pending_outcomes.push_back(res);
        popped++;
        for (int i = 0; i < shadow_count - 1; i++) begin
          shadow_times[i] = shadow_times[i+1];
          shadow_tags[i]  = shadow_tags[i+1];
        end
        shadow_count--;
      end
      if (popped == 0) begin
        res = '{saq_pkg::KindNone, '0, 1'b1};
        pending_outcomes.push_back(res);
      end else begin
        pending_outcomes[pending_outcomes.size()-1].last = 1'b1;
      end
    end
  endfunction

  function automatic void add_item(logic item_op, logic [TIME_BITS-1:0] t,
                                   logic [TAG_BITS-1:0] tag);
    alarm_item_t item;
    item = '{item_op, t, tag};
    stim_items.push_back(item);
  endfunction

  // Driver: bursts of transactions separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    alarm_item_t nxt;
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      op         <= OP_ADD;
      event_time <= '0;
      alarm_tag  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        alarm_queue_step('{op, event_time, alarm_tag});
      end
      if (gap_left > 0 || stim_items.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        nxt = stim_items.pop_front();
        op         <= nxt.op;
        event_time <= nxt.event_time;
        alarm_tag  <= nxt.alarm_tag;
        in_valid   <= 1'b1;
        if (burst_left <= 1) begin
          // now and then a long burst with no gaps at all
          burst_left <= ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
          gap_left   <= $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: changing stall patterns plus one long hold-off
  int  ready_mode = READY_ALWAYS;
  int  mode_left  = 0;
  int  hold_left  = 0;
  logic hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      ready_mode <= READY_ALWAYS;
      mode_left  <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= (hold_left == 1);
    end else if (!hold_done && results_seen >= HOLD_TRIGGER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(READY_ALWAYS, READY_SPARSE);
        mode_left  <= $urandom_range(5, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_HALF:   out_ready <= 1'($urandom_range(0, 1));
        default:      out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: compare each result transaction with the oldest expected one
  always @(posedge clk_i) begin : check_proc
    outcome_t exp_res;
    if (rst_ni && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: kind %0d tag %h last %0d", kind, due_tag, last);
      end else begin
        exp_res = pending_outcomes.pop_front();
        if (kind !== exp_res.kind || due_tag !== exp_res.tag || last !== exp_res.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected kind %0d tag %h last %0d, got kind %0d tag %h last %0d",
                     exp_res.kind, exp_res.tag, exp_res.last, kind, due_tag, last);
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : main_proc
    logic [TIME_BITS-1:0] base;
    logic [TIME_BITS-1:0] t;

    // directed: empty ticks, extreme times and tags, ties, mid insert, exact-time pops
    add_item(OP_TICK, '0, '0);
    add_item(OP_TICK, '1, '1);
    add_item(OP_ADD, '1, '1);
    add_item(OP_ADD, '0, '0);
    add_item(OP_ADD, 32'd100, 16'd1);
    add_item(OP_ADD, 32'd100, 16'd2);
    add_item(OP_ADD, 32'd100, 16'd3);
    add_item(OP_ADD, 32'd50, 16'd4);
    add_item(OP_TICK, '0, 16'h1234);
    add_item(OP_TICK, 32'd49, '0);
    add_item(OP_TICK, 32'd100, '0);
    add_item(OP_TICK, 32'hFFFF_FFFE, '0);
    add_item(OP_TICK, '1, '0);
    add_item(OP_ADD, 32'hAAAA_AAAA, 16'hA5A5);
    add_item(OP_ADD, 32'h5555_5555, 16'h5A5A);
    add_item(OP_TICK, '1, '1);
    add_item(OP_TICK, 32'd7, '0);

    // fill past capacity with clustered times, then drain everything in one tick
    base = $urandom_range(0, 32'hFFFF_0000);
    for (int i = 0; i < DEPTH + 3; i++)
      add_item(OP_ADD, base + $urandom_range(0, 15), TAG_BITS'($urandom_range(0, 16'hFFFF)));
    add_item(OP_TICK, '1, TAG_BITS'($urandom_range(0, 16'hFFFF)));

    // mixed adds and ticks around a slowly advancing time
    base = $urandom_range(0, 32'hFFFF_0000);
    while (stim_items.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 55) begin
        t = ($urandom_range(0, 9) == 0) ? $urandom() : base + $urandom_range(0, 40);
        add_item(OP_ADD, t, TAG_BITS'($urandom_range(0, 16'hFFFF)));
      end else begin
        base = base + $urandom_range(0, 20);
        t = ($urandom_range(0, 19) == 0) ? $urandom() : base + $urandom_range(0, 10);
        add_item(OP_TICK, t, TAG_BITS'($urandom_range(0, 16'hFFFF)));
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_items.size() > 0 || in_valid || pending_outcomes.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #TIMEOUT_NS;
    $display("timeout with %0d results outstanding", pending_outcomes.size());
    $display("status: fail");
    $finish;
  end

endmodule
